// ===== design/box_blur_3x3_edge_normalized_assert.svh =====
// Assertion macros for the 3x3 box blur.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef BOX_BLUR_3X3_EDGE_NORMALIZED_ASSERT_SVH
`define BOX_BLUR_3X3_EDGE_NORMALIZED_ASSERT_SVH
`ifndef SYNTHESIS
`define BB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define BB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BB_ASSERT_IMP(lbl, ante, cons, msg)
`define BB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/bb3_pkg.sv =====
// Package for the 3x3 box blur: types, constants and the reciprocal table.
// No dependencies.
`timescale 1ns / 1ps
package bb3_pkg;

  localparam int FW_BITS   = 11;
  localparam int FH_BITS   = 13;
  localparam int CFG_BITS  = 13;
  localparam int CH_BITS   = 8;
  localparam int PIX_BITS  = 24;
  localparam int SUM_BITS  = 12;
  localparam int CNT_BITS  = 4;
  localparam int RCP_BITS  = 17;
  localparam int RCP_SHIFT = 16;
  localparam int PROD_BITS = SUM_BITS + RCP_BITS;
  localparam int QP_BITS   = 9;
  localparam int REM_BITS  = 13;

  localparam logic [FW_BITS-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_SUM,
    ST_MUL,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic take;
    logic upd;
    logic sum;
    logic mul;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic ignore;
    logic has_result;
    logic out_free;
  } sts_t;

  // floor(2^16 / count) for the neighbour counts that occur
  function automatic logic [RCP_BITS-1:0] recip(input logic [CNT_BITS-1:0] cnt);
    logic [RCP_BITS-1:0] r;
    case (cnt)
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21845;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10922;
      4'd9:    r = 17'd7281;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

// ===== design/bb3_ram.sv =====
// Generic simple dual-port RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module bb3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bb3_ctrl.sv =====
// Controller of the 3x3 box blur: sequences one transaction at a time.
// Depends on bb3_pkg.
`timescale 1ns / 1ps
module bb3_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  bb3_pkg::sts_t sts_i,
  output logic         in_ready_o,
  output bb3_pkg::cmd_t cmd_o
);
  import bb3_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i && !sts_i.ignore) state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = sts_i.has_result ? ST_SUM : ST_IDLE;
      end
      ST_SUM:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_FIN;
      ST_FIN: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = s_valid_i && !sts_i.ignore;
      end
      ST_UPD:  cmd_o.upd = 1'b1;
      ST_SUM:  cmd_o.sum = 1'b1;
      ST_MUL:  cmd_o.mul = 1'b1;
      ST_FIN:  cmd_o.fin = sts_i.out_free;
      default: cmd_o     = '0;
    endcase
  end

endmodule

// ===== design/bb3_datapath.sv =====
// Datapath of the 3x3 box blur: line store, window, counters, divide, output register.
// Depends on bb3_pkg and bb3_ram.
`timescale 1ns / 1ps
module bb3_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_idx_i,
  input  logic [bb3_pkg::CFG_BITS-1:0]      cfg_data_i,
  input  logic [bb3_pkg::PIX_BITS-1:0]      s_tdata_i,
  input  logic                              s_tuser_i,
  input  bb3_pkg::cmd_t                     cmd_i,
  output bb3_pkg::sts_t                     sts_o,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [bb3_pkg::PIX_BITS-1:0]      m_tdata_o,
  output logic                              m_tlast_o
);
  import bb3_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH + 2);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);

  logic [FW_BITS-1:0] frame_width_q;
  logic [FH_BITS-1:0] frame_height_q;
  logic [WW-1:0]      w_eff;
  logic [HW-1:0]      h_eff;
  logic [PW-1:0]      wh_q;

  logic [CW-1:0] in_col_q, in_col_inc;
  logic [HW-1:0] in_row_q;
  logic [PW-1:0] in_pos_q;
  logic [WW-1:0] out_col_q;
  logic [HW-1:0] out_row_q;
  logic [PW-1:0] out_pos_q;

  logic [PIX_BITS-1:0]   pix_q;
  logic [PIX_BITS-1:0]   win_q [3][3];
  logic [PIX_BITS-1:0]   col_new [3];
  logic [2*PIX_BITS-1:0] rd_data;
  logic                  filling, col_ok, last;
  logic [2:0]            colv_q, rowv_q;

  logic [SUM_BITS-1:0]  sum_d [3];
  logic [SUM_BITS-1:0]  n_q [3];
  logic [CNT_BITS-1:0]  cnt_d, cnt_q;
  logic [RCP_BITS-1:0]  rcp_q;
  logic [PROD_BITS-1:0] prod [3];
  logic [QP_BITS-1:0]   qp_q [3];
  logic [REM_BITS-1:0]  rem [3];
  logic [PIX_BITS-1:0]  res;
  logic                 m_valid_q;

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_q);
    end
  end

  always_ff @(posedge clk_i) begin
    wh_q <= PW'(32'(w_eff) * 32'(h_eff));
  end

  assign filling    = 32'(in_row_q) < 32'(h_eff);
  assign col_ok     = 32'(in_col_q) < 32'(w_eff);
  assign in_col_inc = in_col_q + CW'(1);
  assign last       = 32'(out_pos_q) + 32'd1 >= 32'(wh_q);

  assign sts_o.ignore     = s_tuser_i && filling;
  assign sts_o.has_result = 32'(in_pos_q) >= 32'(w_eff) + 32'd1;
  assign sts_o.out_free   = !m_valid_q || m_tready_i;

  // upper line in the high half, middle line in the low half
  bb3_ram #(
    .WIDTH(2 * PIX_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk_i  (clk_i),
    .we_i   (cmd_i.upd && col_ok && filling),
    .waddr_i(in_col_q[AW-1:0]),
    .wdata_i({rd_data[PIX_BITS-1:0], pix_q}),
    .re_i   (cmd_i.take),
    .raddr_i(in_col_q[AW-1:0]),
    .rdata_o(rd_data)
  );

  assign col_new[0] = col_ok ? rd_data[2*PIX_BITS-1:PIX_BITS] : '0;
  assign col_new[1] = col_ok ? rd_data[PIX_BITS-1:0] : '0;
  assign col_new[2] = (col_ok && filling) ? pix_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      in_col_q       <= '0;
      in_row_q       <= '0;
      in_pos_q       <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
      out_pos_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_BITS-1:0];
        default:          frame_width_q  <= frame_width_q;
      endcase
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_pos_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      out_pos_q <= '0;
    end else if (cmd_i.upd) begin
      in_pos_q <= in_pos_q + PW'(1);
      if (filling && 32'(in_col_inc) >= 32'(w_eff)) begin
        in_col_q <= '0;
        in_row_q <= in_row_q + HW'(1);
      end else begin
        in_col_q <= in_col_inc;
      end
    end else if (cmd_i.fin) begin
      if (last) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        in_pos_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
        out_pos_q <= '0;
      end else begin
        out_pos_q <= out_pos_q + PW'(1);
        if (32'(out_col_q) + 32'd1 >= 32'(w_eff)) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + HW'(1);
        end else begin
          out_col_q <= out_col_q + WW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (cmd_i.upd) begin
      for (int j = 0; j < 3; j++) begin
        win_q[0][j] <= win_q[1][j];
        win_q[1][j] <= win_q[2][j];
        win_q[2][j] <= col_new[j];
      end
    end
  end

  // neighbour masks: bit 0 left/up, bit 2 right/down
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pix_q <= s_tdata_i;
    end
    if (cmd_i.upd) begin
      colv_q <= {32'(out_col_q) + 32'd1 < 32'(w_eff), 1'b1, out_col_q != '0};
      rowv_q <= {32'(out_row_q) + 32'd1 < 32'(h_eff), 1'b1, out_row_q != '0};
    end
  end

  always_comb begin
    cnt_d = CNT_BITS'($countones(colv_q)) * CNT_BITS'($countones(rowv_q));
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (colv_q[i] && rowv_q[j]) begin
            sum_d[ch] = sum_d[ch] + SUM_BITS'(win_q[i][j][CH_BITS*(2-ch) +: CH_BITS]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_BITS'(n_q[ch]) * PROD_BITS'(rcp_q);
      rem[ch]  = REM_BITS'(n_q[ch]) - REM_BITS'(qp_q[ch]) * REM_BITS'(cnt_q);
      res[CH_BITS*(2-ch) +: CH_BITS] =
        CH_BITS'(qp_q[ch] + QP_BITS'(rem[ch] >= REM_BITS'(cnt_q)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      cnt_q <= cnt_d;
      rcp_q <= recip(cnt_d);
      for (int ch = 0; ch < 3; ch++) begin
        n_q[ch] <= sum_d[ch] + SUM_BITS'(cnt_d >> 1);
      end
    end
    if (cmd_i.mul) begin
      for (int ch = 0; ch < 3; ch++) begin
        qp_q[ch] <= QP_BITS'(prod[ch] >> RCP_SHIFT);
      end
    end
    if (cmd_i.fin) begin
      m_tdata_o <= {res[7:0], res[15:8], res[23:16]};
      m_tlast_o <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = m_valid_q;

endmodule

// ===== design/box_blur_3x3_edge_normalized.sv =====
// Channel      | Direction | Contents
// s_axis       | in        | tdata red/green/blue, tuser mode (1 = flush)
// m_axis       | out       | tdata red/green/blue, tlast frame end
// cfg          | in        | write enable, index, data (frame width, frame height)
// A pixel with a result goes through accept, line store read and window update,
// sum, reciprocal multiply and correction (held while the output is full); one
// without a result ends after the update. The next pixel waits until it is done.
// A flush before the last pixel is accepted and dropped. No clearing pass after reset.
// A result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps
`include "box_blur_3x3_edge_normalized_assert.svh"
module box_blur_3x3_edge_normalized #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [bb3_pkg::CFG_BITS-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [bb3_pkg::PIX_BITS-1:0]  s_axis_tdata_i,  // in_red, in_green, in_blue
  input  logic                          s_axis_tuser_i,  // mode
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [bb3_pkg::PIX_BITS-1:0]  m_axis_tdata_o,  // out_red, out_green, out_blue
  output logic                          m_axis_tlast_o
);
  import bb3_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bb3_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .sts_i     (sts),
    .in_ready_o(s_axis_tready_o),
    .cmd_o     (cmd)
  );

  bb3_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .s_tdata_i ({s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tdata_i[23:16]}),
    .s_tuser_i (s_axis_tuser_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tready_i(m_axis_tready_i),
    .m_tdata_o (m_axis_tdata_o),
    .m_tlast_o (m_axis_tlast_o)
  );

  `BB_ASSERT_NXT(a_take_busy, cmd.take, !s_axis_tready_o, "ready held after transaction")
  `BB_ASSERT_NXT(a_no_result_idle, cmd.upd && !sts.has_result, s_axis_tready_o, "no return to idle")
  `BB_ASSERT_NXT(a_fin_valid, cmd.fin, m_axis_tvalid_o, "result not presented")

endmodule
